/* sv/tmf_pkg.sv */
// ----------------------------------------------------------------------------
// tmf_pkg
// Shared types and fixed widths for the trimmed mean ADC filter.
// ----------------------------------------------------------------------------
package tmf_pkg;

  localparam int RAW_W      = 16;
  localparam int SAMPLE_W   = 12;
  localparam int MV_W       = 13;
  localparam int VREF_W     = 13;
  localparam int MAX_CH     = 7;
  localparam int FS_SHIFT   = 12;   // full scale of 4096 codes
  localparam int IN_DATA_W  = MAX_CH * RAW_W;
  localparam int OUT_DATA_W = ((MAX_CH * MV_W + 7) / 8) * 8;

  localparam logic [VREF_W-1:0] VREF_RESET = 13'd3300;

  // strobes from the sequencer to every lane
  typedef struct packed {
    logic wr_en;
    logic scan_en;
    logic scan_first;
    logic trim_en;
    logic mul_en;
    logic div_en;
  } lane_ctrl_t;

endpackage

/* sv/tmf_lane.sv */
// ----------------------------------------------------------------------------
// tmf_lane
// One channel: sample ring, sum/min/max scan, trim and millivolt scaling.
// ----------------------------------------------------------------------------
module tmf_lane import tmf_pkg::*; #(
  parameter int WINDOW = 10
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  lane_ctrl_t                 ctl,
  input  logic [$clog2(WINDOW)-1:0]  wr_slot,
  input  logic [$clog2(WINDOW)-1:0]  scan_idx,
  input  logic [SAMPLE_W-1:0]        sample_in,
  input  logic [VREF_W-1:0]          vref,
  output logic [MV_W-1:0]            mv_out
);

  localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW);
  localparam int PROD_W = SUM_W + VREF_W;
  localparam int SCL_W  = PROD_W - FS_SHIFT;
  localparam int DIVR   = WINDOW - 2;
  localparam int RSH    = SCL_W + $clog2(DIVR);
  localparam int Q_W    = SCL_W + RSH + 1;
  localparam longint unsigned RECIP_L = ((64'd1 << RSH) + DIVR - 1) / DIVR;
  localparam logic [RSH:0] RECIP = RECIP_L[RSH:0];

  logic [SAMPLE_W-1:0] win_r [WINDOW];
  logic [SAMPLE_W-1:0] rd_s;
  logic [SUM_W-1:0]    sum_r;
  logic [SAMPLE_W-1:0] lo_r;
  logic [SAMPLE_W-1:0] hi_r;
  logic [SUM_W-1:0]    trim_r;
  logic [PROD_W-1:0]   prod_r;
  logic [Q_W-1:0]      q_r;
  logic [SCL_W-1:0]    scl;

  assign rd_s = win_r[scan_idx];
  assign scl  = prod_r[PROD_W-1:FS_SHIFT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WINDOW; i++) begin
        win_r[i] <= '0;
      end
    end else if (ctl.wr_en) begin
      win_r[wr_slot] <= sample_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.scan_en) begin
      if (ctl.scan_first) begin
        sum_r <= SUM_W'(rd_s);
        lo_r  <= rd_s;
        hi_r  <= rd_s;
      end else begin
        sum_r <= sum_r + SUM_W'(rd_s);
        if (rd_s < lo_r) lo_r <= rd_s;
        if (rd_s > hi_r) hi_r <= rd_s;
      end
    end
    if (ctl.trim_en) begin
      trim_r <= sum_r - SUM_W'(lo_r) - SUM_W'(hi_r);
    end
    if (ctl.mul_en) begin
      prod_r <= PROD_W'(trim_r) * PROD_W'(vref);
    end
    // divide by window-2 through a rounded-up reciprocal, exact over the range
    if (ctl.div_en) begin
      q_r <= Q_W'(scl) * Q_W'(RECIP);
    end
  end

  assign mv_out = q_r[RSH +: MV_W];

endmodule

/* sv/tmf_ctrl.sv */
// ----------------------------------------------------------------------------
// tmf_ctrl
// Sequencer: ring slot, fill count, window scan and scaling steps.
// ----------------------------------------------------------------------------
module tmf_ctrl import tmf_pkg::*; #(
  parameter int WINDOW = 10
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       out_free,
  output logic                       in_ready,
  output logic                       done,
  output logic                       window_full,
  output lane_ctrl_t                 ctl,
  output logic [$clog2(WINDOW)-1:0]  wr_slot,
  output logic [$clog2(WINDOW)-1:0]  scan_idx
);

  localparam int IDX_W  = $clog2(WINDOW);
  localparam int FILL_W = $clog2(WINDOW + 1);
  localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(WINDOW - 1);
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WINDOW);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_TRIM,
    ST_MUL,
    ST_DIV,
    ST_HOLD
  } state_t;

  state_t              state_r;
  logic [IDX_W-1:0]    slot_r;
  logic [IDX_W-1:0]    idx_r;
  logic [FILL_W-1:0]   fill_r;
  logic                accept;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign done     = (state_r == ST_HOLD) && out_free;
  assign wr_slot  = slot_r;
  assign scan_idx = idx_r;
  assign window_full = (fill_r >= FILL_FULL);

  always_comb begin
    ctl            = '0;
    ctl.wr_en      = accept;
    ctl.scan_en    = (state_r == ST_SCAN);
    ctl.scan_first = (state_r == ST_SCAN) && (idx_r == '0);
    ctl.trim_en    = (state_r == ST_TRIM);
    ctl.mul_en     = (state_r == ST_MUL);
    ctl.div_en     = (state_r == ST_DIV);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      slot_r  <= '0;
      idx_r   <= '0;
      fill_r  <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            state_r <= ST_SCAN;
            idx_r   <= '0;
            slot_r  <= (slot_r == LAST_IDX) ? '0 : slot_r + 1'b1;
            if (fill_r < FILL_FULL) fill_r <= fill_r + 1'b1;
          end
        end
        ST_SCAN: begin
          if (idx_r == LAST_IDX) begin
            state_r <= ST_TRIM;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        ST_TRIM: state_r <= ST_MUL;
        ST_MUL:  state_r <= ST_DIV;
        ST_DIV:  state_r <= ST_HOLD;
        ST_HOLD: begin
          if (out_free) state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_FULL)
    else $error("fill count beyond window");

  a_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
    slot_r <= LAST_IDX)
    else $error("write slot outside ring");

  a_scan_start: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_SCAN) && (idx_r == '0))
    else $error("scan did not start at first entry");

  a_scan_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) && (idx_r == LAST_IDX) |=> state_r == ST_TRIM)
    else $error("scan overran the window");

endmodule

/* sv/trimmed_mean_adc_filter.sv */
// ----------------------------------------------------------------------------
// trimmed_mean_adc_filter
// Olympic trimmed mean over a moving window, one lane per ADC channel.
//
//   channel  dir  fields
//   in_      in   tdata: raw_ch0 .. raw_ch6, 16 bits each
//   out_     out  tdata: mv_ch0 .. mv_ch6, 13 bits each; tuser: window_full
//   cfg_     in   wr_data: vref_millivolts
//
// a snapshot writes the ring, scans each lane's ring a sample a cycle, then
// trims, multiplies by vref and divides by window-2 through a reciprocal,
// and hands over the result.
// reset clears the rings, slot, fill count and sets vref to 3300.
// a stalled result sits in the output register while the next snapshot is
// taken; the lanes hold their result until the register frees.
// ----------------------------------------------------------------------------
module trimmed_mean_adc_filter import tmf_pkg::*; #(
  parameter int WINDOW   = 10,
  parameter int CHANNELS = 7
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,    // raw_ch0 .. raw_ch6
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,   // mv_ch0 .. mv_ch6, zero pad
  output logic [0:0]            out_tuser,   // window_full
  input  logic                  cfg_wr_en,
  input  logic [VREF_W-1:0]     cfg_wr_data  // vref_millivolts
);

  localparam int IDX_W = $clog2(WINDOW);

  lane_ctrl_t        ctl;
  logic [IDX_W-1:0]  wr_slot;
  logic [IDX_W-1:0]  scan_idx;
  logic              done;
  logic              window_full;
  logic              out_free;
  logic [VREF_W-1:0] vref_r;
  logic [MV_W-1:0]   mv [MAX_CH];
  logic [OUT_DATA_W-1:0] mv_packed;

  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                  out_full_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vref_r <= VREF_RESET;
    end else if (cfg_wr_en) begin
      vref_r <= cfg_wr_data;
    end
  end

  assign out_free = !out_valid_r || out_tready;

  tmf_ctrl #(.WINDOW(WINDOW)) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .out_free    (out_free),
    .in_ready    (in_tready),
    .done        (done),
    .window_full (window_full),
    .ctl         (ctl),
    .wr_slot     (wr_slot),
    .scan_idx    (scan_idx)
  );

  for (genvar ch = 0; ch < MAX_CH; ch++) begin : g_lane
    if (ch < CHANNELS) begin : g_on
      tmf_lane #(.WINDOW(WINDOW)) u_lane (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .wr_slot   (wr_slot),
        .scan_idx  (scan_idx),
        .sample_in (in_tdata[ch*RAW_W +: SAMPLE_W]),
        .vref      (vref_r),
        .mv_out    (mv[ch])
      );
    end else begin : g_off
      assign mv[ch] = '0;
    end
  end

  // merge the lane results into one beat
  always_comb begin
    mv_packed = '0;
    for (int ch = 0; ch < MAX_CH; ch++) begin
      mv_packed[ch*MV_W +: MV_W] = mv[ch];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_data_r <= mv_packed;
      out_full_r <= window_full;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_full_r;

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the trimmed mean ADC filter against a predictor of the seven channel
// rings. Every accepted snapshot yields one expected readout, and each output
// beat is compared field by field. Directed extremes and window fill come
// first, then random snapshots under several reference voltages, with bursty
// input and a stalling receiver.
// ----------------------------------------------------------------------------
module testbench import tmf_pkg::*; ();

  localparam int WINDOW        = 10;
  localparam int CHANNELS      = 7;
  localparam int SETTLE_CYCLES = 40;
  localparam int QUIET_LIMIT   = 2000;
  localparam int PHASE_ITEMS   = 45;

  typedef struct packed {
    logic                         full;
    logic [MAX_CH-1:0][MV_W-1:0]  mv;
  } mv_frame_t;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_CHOKE, RX_CADENCE} rx_mode_e;

  class millivolt_tracker;
    logic [SAMPLE_W-1:0] ring [MAX_CH][WINDOW];
    int unsigned         slot;
    int unsigned         seen;
    logic [VREF_W-1:0]   vref;
    mv_frame_t           awaited[$];
    int unsigned         readouts;
    int unsigned         errors;

    function new();
      foreach (ring[c, i]) ring[c][i] = '0;
      slot     = 0;
      seen     = 0;
      vref     = VREF_RESET;
      readouts = 0;
      errors   = 0;
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction

    function void note_snapshot(logic [IN_DATA_W-1:0] snap);
      mv_frame_t       frame;
      longint unsigned sum, lo, hi, s;
      int              c, i;
      frame = '0;
      for (c = 0; c < CHANNELS; c++) begin
        ring[c][slot] = snap[c*RAW_W +: SAMPLE_W];
        sum = 0;
        lo  = 64'hFFFF;
        hi  = 0;
        for (i = 0; i < WINDOW; i++) begin
          s = ring[c][i];
          sum += s;
          if (s < lo) lo = s;
          if (s > hi) hi = s;
        end
        // one minimum and one maximum dropped, whatever the duplicates
        s = (sum - lo - hi) * vref / ((WINDOW - 2) << FS_SHIFT);
        if (s > 2**MV_W - 1) s = 2**MV_W - 1;
        frame.mv[c] = s[MV_W-1:0];
      end
      slot = (slot + 1) % WINDOW;
      if (seen < WINDOW) seen++;
      frame.full = (seen >= WINDOW);
      awaited.push_back(frame);
    endfunction

    task report_mismatch(string msg);
      $display("readout %0d: %s", readouts, msg);
      errors++;
    endtask

    task check_readout(logic [OUT_DATA_W-1:0] data, logic full);
      mv_frame_t want;
      int        c;
      readouts++;
      if (awaited.size() == 0) begin
        report_mismatch("output beat with no snapshot outstanding");
        return;
      end
      want = awaited.pop_front();
      for (c = 0; c < MAX_CH; c++) begin
        if (data[c*MV_W +: MV_W] !== want.mv[c])
          report_mismatch($sformatf("mv_ch%0d got %0d expected %0d",
                                    c, data[c*MV_W +: MV_W], want.mv[c]));
      end
      if (full !== want.full)
        report_mismatch($sformatf("window_full got %b expected %b", full, want.full));
    endtask
  endclass

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  in_tvalid   = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata    = '0;
  logic                  out_tvalid;
  logic                  out_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [0:0]            out_tuser;
  logic                  cfg_wr_en   = 1'b0;
  logic [VREF_W-1:0]     cfg_wr_data = '0;

  millivolt_tracker      tracker;
  int unsigned           burst_left  = 0;
  int unsigned           quiet_cycles = 0;
  logic [IN_DATA_W-1:0]  prev_snap   = '0;
  rx_mode_e              rx_mode     = RX_OPEN;
  int unsigned           rx_left     = 0;
  int unsigned           cadence_cnt = 0;

  trimmed_mean_adc_filter #(
    .WINDOW  (WINDOW),
    .CHANNELS(CHANNELS)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),     // raw_ch0 .. raw_ch6
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),    // mv_ch0 .. mv_ch6, zero pad
    .out_tuser  (out_tuser),    // window_full
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)   // vref_millivolts
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver stall pattern, changing character at random
  always @(posedge clk) begin
    cadence_cnt <= cadence_cnt + 1;
    if (rx_left == 0) begin
      rx_mode <= rx_mode_e'($urandom_range(0, 3));
      rx_left <= $urandom_range(50, 300);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_OPEN:  out_tready <= 1'b1;
      RX_COIN:  out_tready <= 1'($urandom_range(0, 1));
      RX_CHOKE: out_tready <= ($urandom_range(0, 7) == 0);
      default:  out_tready <= (cadence_cnt % 7) < 3;
    endcase
  end

  // output beat checked before the input beat of the same edge is noted
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) tracker.check_readout(out_tdata, out_tuser[0]);
      if (in_tvalid && in_tready) tracker.note_snapshot(in_tdata);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("trimmed_mean_adc_filter test failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic logic [IN_DATA_W-1:0] fill(input logic [RAW_W-1:0] w);
    return {MAX_CH{w}};
  endfunction

  function automatic logic [IN_DATA_W-1:0] random_snapshot();
    logic [IN_DATA_W-1:0] snap;
    logic [RAW_W-1:0]     raw;
    int                   flavour;
    int                   ch;
    flavour = $urandom_range(0, 9);
    for (ch = 0; ch < MAX_CH; ch++) begin
      case (flavour)
        0, 1, 2, 3, 4: raw = 16'($urandom);
        5, 6:          raw = {4'($urandom), ($urandom_range(0, 1) ? 12'hFFF : 12'h000)};
        7:             raw = {4'($urandom), 12'($urandom_range(0, 15))};
        8:             raw = prev_snap[ch*RAW_W +: RAW_W];
        default:       raw = {4'($urandom), 12'(2016 + $urandom_range(0, 64))};
      endcase
      snap[ch*RAW_W +: RAW_W] = raw;
    end
    return snap;
  endfunction

  task automatic push_snapshot(input logic [IN_DATA_W-1:0] snap);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                               : $urandom_range(1, 6);
      in_tvalid <= 1'b0;
      in_tdata  <= IN_DATA_W'({$urandom, $urandom, $urandom, $urandom});
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= snap;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    burst_left--;
    prev_snap = snap;
  endtask

  // only once the filter has drained and gone quiet
  task automatic set_vref(input logic [VREF_W-1:0] v);
    in_tvalid <= 1'b0;
    // let the last accepted beat be noted before counting what is outstanding
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= VREF_W'($urandom);
    tracker.vref = v;
    burst_left   = 0;
  endtask

  initial begin
    logic [VREF_W-1:0]    vrefs [8];
    logic [IN_DATA_W-1:0] snap;
    int                   k, ch, p;
    tracker = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // window fills from zero at the reset reference
    push_snapshot(fill(16'hFFFF));
    push_snapshot(fill(16'h0000));
    push_snapshot(fill(16'hF000));
    push_snapshot(fill(16'h0FFF));
    for (k = 0; k < 6; k++) begin
      for (ch = 0; ch < MAX_CH; ch++)
        snap[ch*RAW_W +: RAW_W] = {4'(k * 3 + ch), 12'((ch + 1) * 512 + k * 37)};
      push_snapshot(snap);
    end
    push_snapshot(fill(16'hFFFF));
    push_snapshot(fill(16'hFFFF));
    push_snapshot(fill(16'hAAAA));
    push_snapshot(fill(16'h5555));
    push_snapshot(fill(16'h0001));
    push_snapshot(fill(16'h8FFE));

    vrefs[0] = '0;
    vrefs[1] = '1;
    vrefs[2] = 13'd1;
    vrefs[3] = 13'd5000;
    vrefs[4] = VREF_W'($urandom_range(0, 8191));
    vrefs[5] = VREF_W'($urandom_range(1, 5000));
    vrefs[6] = VREF_W'($urandom_range(0, 8191));
    vrefs[7] = VREF_RESET;
    for (p = 0; p < 8; p++) begin
      set_vref(vrefs[p]);
      // a full window of maximum codes at the largest reference
      if (vrefs[p] == '1) begin
        for (k = 0; k < WINDOW; k++) push_snapshot(fill(16'hFFFF));
      end
      for (k = 0; k < PHASE_ITEMS; k++) push_snapshot(random_snapshot());
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.errors == 0)
      $display("trimmed_mean_adc_filter test passed");
    else
      $display("trimmed_mean_adc_filter test failed");
    $finish;
  end

endmodule

/* trimmed_mean_adc_filter.f */
sv/tmf_pkg.sv
sv/tmf_lane.sv
sv/tmf_ctrl.sv
sv/trimmed_mean_adc_filter.sv
test/testbench.sv
